// ===== src/vbd_pkg.sv =====
package vbd_pkg;

   localparam int COORD_BITS = 32;
   localparam int ADDR_BITS  = 5;
   localparam int QBITS      = 25;
   localparam int WBITS      = 17;
   localparam int DQ_STEPS   = QBITS;
   localparam int WD_STEPS   = WBITS;
   localparam int PIPE_DEPTH = 2 + DQ_STEPS + 2 + 1 + WD_STEPS + 1;

   localparam logic [30:0] RADIUS_MIN   = 31'd6554;
   localparam logic [30:0] RADIUS_RESET = 31'd65536;
   localparam logic [QBITS-1:0] Q_CLAMP = QBITS'(1) << (QBITS - 1);
   localparam logic [32:0] ONE_Q16      = 33'd65536;

   localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (COORD_BITS - 1)) - 35'sd1;
   localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_PUSH_X   = 3'd3,
      REG_PUSH_Y   = 3'd4,
      REG_PUSH_Z   = 3'd5,
      REG_RADIUS   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [2:0][31:0] v;
      logic [15:0]      idx;
   } carry_type;

   typedef struct packed {
      logic [30:0]      rem;
      logic [24:0]      low;
      logic [QBITS-1:0] quo;
      logic             ovf;
   } qdiv_type;

   typedef struct packed {
      logic [32:0]      rem;
      logic [16:0]      low;
      logic [WBITS-1:0] quo;
      logic [32:0]      den;
   } wdiv_type;

endpackage

// ===== src/vertex_bulge_deform_core.sv =====
// Bulge deformation of a stream of vertices.
// A vertex transaction is offered on req_vertex_x/y/z (signed Q16.16) with
// req_vertex_index and is taken at a rising edge where start is high and
// busy is low. busy is always low, so one vertex may be taken every cycle.
// The moved vertex appears on the rsp_ ports for exactly one cycle, marked
// by rsp_strobe, once its vertex has passed through the whole pipeline.
// Results leave in the order the vertices arrived, one per cycle at most.
// The delay is set by the pipeline: one quotient bit per stage for the
// three offset divisions (25 stages), one bit per stage for the weight
// division (17 stages), and the multiply, sum and add stages around them.
// The receiver cannot stall, so nothing is ever held back.
// The registers sit on an APB-style port at byte address 4*index: centre
// x/y/z, push x/y/z, then falloff radius. Writes complete in the access
// phase; pready is always high. The user must write the registers only
// while the pipeline is empty; the block itself does not enforce this.
// Synchronous reset clears the pipeline valid bits, the result strobe and
// the registers (radius to 1.0, the others to zero).
module vertex_bulge_deform_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [31:0]                   req_vertex_x,
   input  logic [31:0]                   req_vertex_y,
   input  logic [31:0]                   req_vertex_z,
   input  logic [15:0]                   req_vertex_index,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_moved_x,
   output logic [31:0]                   rsp_moved_y,
   output logic [31:0]                   rsp_moved_z,
   output logic [15:0]                   rsp_moved_index,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vbd_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import vbd_pkg::*;

   logic [2:0][31:0] center_ff, center_in;
   logic [2:0][31:0] push_ff, push_in;
   logic [30:0]      radius_ff, radius_in;
   logic [30:0]      radius;

   logic      vld_ff [PIPE_DEPTH];
   logic      vld_in [PIPE_DEPTH];
   carry_type car_ff [PIPE_DEPTH];
   carry_type car_in [PIPE_DEPTH];

   logic [32:0] mag_ff [3];
   logic [32:0] mag_in [3];
   qdiv_type    dq_ff [DQ_STEPS+1][3];
   qdiv_type    dq_in [DQ_STEPS+1][3];
   logic [48:0] sq_ff [3];
   logic [48:0] sq_in [3];
   logic [31:0] d_ff, d_in;
   wdiv_type    wd_ff [WD_STEPS+1];
   wdiv_type    wd_in [WD_STEPS+1];
   logic [48:0] prod_ff [3];
   logic [48:0] prod_in [3];

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [2:0][31:0] rsp_moved_ff, rsp_moved_in;
   logic [15:0]      rsp_index_ff, rsp_index_in;

   logic             accept;
   logic             cfg_write;
   logic [2:0][31:0] req_v;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start & ~busy;
   assign cfg_write = psel & penable & pwrite & pready;
   assign req_v  = {req_vertex_z, req_vertex_y, req_vertex_x};
   assign radius = (radius_ff < RADIUS_MIN) ? RADIUS_MIN : radius_ff;

   always_comb begin
      center_in = center_ff;
      push_in   = push_ff;
      radius_in = radius_ff;
      if (cfg_write) begin
         case (reg_index_type'(paddr[4:2]))
            REG_CENTER_X: center_in[0] = pwdata;
            REG_CENTER_Y: center_in[1] = pwdata;
            REG_CENTER_Z: center_in[2] = pwdata;
            REG_PUSH_X:   push_in[0]   = pwdata;
            REG_PUSH_Y:   push_in[1]   = pwdata;
            REG_PUSH_Z:   push_in[2]   = pwdata;
            REG_RADIUS:   radius_in    = pwdata[30:0];
            default:      radius_in    = radius_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_CENTER_X: prdata = center_ff[0];
         REG_CENTER_Y: prdata = center_ff[1];
         REG_CENTER_Z: prdata = center_ff[2];
         REG_PUSH_X:   prdata = push_ff[0];
         REG_PUSH_Y:   prdata = push_ff[1];
         REG_PUSH_Z:   prdata = push_ff[2];
         REG_RADIUS:   prdata = {1'b0, radius_ff};
         default:      prdata = 32'd0;
      endcase
   end

   always_comb begin
      logic signed [32:0] diff;
      logic [31:0]        tq;
      logic [33:0]        tw;
      logic [50:0]        sum;
      logic [32:0]        den;
      logic [32:0]        num;
      logic [QBITS-1:0]   qv;
      logic [31:0]        pmag;
      logic [48:0]        rnd;
      logic [32:0]        dmag;
      logic signed [34:0] s;

      vld_in[0] = accept;
      car_in[0].v   = req_v;
      car_in[0].idx = req_vertex_index;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         vld_in[k] = vld_ff[k-1];
         car_in[k] = car_ff[k-1];
      end

      for (int a = 0; a < 3; a++) begin
         diff = $signed({req_v[a][31], req_v[a]}) - $signed({center_ff[a][31], center_ff[a]});
         mag_in[a] = diff[32] ? 33'(-diff) : 33'(diff);

         dq_in[0][a].rem = {7'd0, mag_ff[a][32:9]};
         dq_in[0][a].low = {mag_ff[a][8:0], 16'd0};
         dq_in[0][a].quo = '0;
         dq_in[0][a].ovf = {7'd0, mag_ff[a][32:9]} >= radius;
         for (int k = 1; k <= DQ_STEPS; k++) begin
            tq = {dq_ff[k-1][a].rem, dq_ff[k-1][a].low[24]};
            dq_in[k][a].low = {dq_ff[k-1][a].low[23:0], 1'b0};
            dq_in[k][a].ovf = dq_ff[k-1][a].ovf;
            if (tq >= {1'b0, radius}) begin
               dq_in[k][a].rem = 31'(tq - {1'b0, radius});
               dq_in[k][a].quo = {dq_ff[k-1][a].quo[QBITS-2:0], 1'b1};
            end else begin
               dq_in[k][a].rem = tq[30:0];
               dq_in[k][a].quo = {dq_ff[k-1][a].quo[QBITS-2:0], 1'b0};
            end
         end

         if (dq_ff[DQ_STEPS][a].ovf || dq_ff[DQ_STEPS][a].quo > Q_CLAMP) begin
            qv = Q_CLAMP;
         end else begin
            qv = dq_ff[DQ_STEPS][a].quo;
         end
         sq_in[a] = 49'(qv * qv);
      end

      sum = 51'(sq_ff[0]) + 51'(sq_ff[1]) + 51'(sq_ff[2]);
      d_in = (sum[50:48] != 3'd0) ? 32'hFFFF_FFFF : sum[47:16];

      den = ONE_Q16 + {1'b0, d_ff};
      num = 33'h1_0000_0000 + {1'b0, den[32:1]};
      wd_in[0].rem = {17'd0, num[32:17]};
      wd_in[0].low = num[16:0];
      wd_in[0].quo = '0;
      wd_in[0].den = den;
      for (int k = 1; k <= WD_STEPS; k++) begin
         tw = {wd_ff[k-1].rem, wd_ff[k-1].low[16]};
         wd_in[k].low = {wd_ff[k-1].low[15:0], 1'b0};
         wd_in[k].den = wd_ff[k-1].den;
         if (tw >= {1'b0, wd_ff[k-1].den}) begin
            wd_in[k].rem = 33'(tw - {1'b0, wd_ff[k-1].den});
            wd_in[k].quo = {wd_ff[k-1].quo[WBITS-2:0], 1'b1};
         end else begin
            wd_in[k].rem = tw[32:0];
            wd_in[k].quo = {wd_ff[k-1].quo[WBITS-2:0], 1'b0};
         end
      end

      for (int a = 0; a < 3; a++) begin
         pmag = push_ff[a][31] ? 32'(-push_ff[a]) : push_ff[a];
         prod_in[a] = 49'(pmag * wd_ff[WD_STEPS].quo);

         rnd  = prod_ff[a] + 49'd32768;
         dmag = rnd[48:16];
         if (push_ff[a][31]) begin
            s = $signed({{3{car_ff[PIPE_DEPTH-1].v[a][31]}}, car_ff[PIPE_DEPTH-1].v[a]})
                - $signed({2'b00, dmag});
         end else begin
            s = $signed({{3{car_ff[PIPE_DEPTH-1].v[a][31]}}, car_ff[PIPE_DEPTH-1].v[a]})
                + $signed({2'b00, dmag});
         end
         if (s > SAT_HI) begin
            rsp_moved_in[a] = SAT_HI[31:0];
         end else if (s < SAT_LO) begin
            rsp_moved_in[a] = SAT_LO[31:0];
         end else begin
            rsp_moved_in[a] = s[31:0];
         end
      end
      rsp_strobe_in = vld_ff[PIPE_DEPTH-1];
      rsp_index_in  = car_ff[PIPE_DEPTH-1].idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff     <= '0;
         push_ff       <= '0;
         radius_ff     <= RADIUS_RESET;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         center_ff     <= center_in;
         push_ff       <= push_in;
         radius_ff     <= radius_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         car_ff[k] <= car_in[k];
      end
      for (int a = 0; a < 3; a++) begin
         mag_ff[a]  <= mag_in[a];
         sq_ff[a]   <= sq_in[a];
         prod_ff[a] <= prod_in[a];
         for (int k = 0; k <= DQ_STEPS; k++) begin
            dq_ff[k][a] <= dq_in[k][a];
         end
      end
      for (int k = 0; k <= WD_STEPS; k++) begin
         wd_ff[k] <= wd_in[k];
      end
      d_ff         <= d_in;
      rsp_moved_ff <= rsp_moved_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_moved_x     = rsp_moved_ff[0];
   assign rsp_moved_y     = rsp_moved_ff[1];
   assign rsp_moved_z     = rsp_moved_ff[2];
   assign rsp_moved_index = rsp_index_ff;

endmodule
